FILE: rtl/ccsc_pkg.sv
// Package: types, constants and round helpers for the ChaCha stream cipher unit
package ccsc_pkg;

   localparam int unsigned CSR_ADDR_W = 6;

   localparam logic [1:0] REQ_RESTART = 2'd0;
   localparam logic [1:0] REQ_SEEK    = 2'd1;
   localparam logic [1:0] REQ_CIPHER  = 2'd2;

   localparam logic [2:0] REG_KEY01  = 3'd0;
   localparam logic [2:0] REG_KEY23  = 3'd1;
   localparam logic [2:0] REG_KEY45  = 3'd2;
   localparam logic [2:0] REG_KEY67  = 3'd3;
   localparam logic [2:0] REG_NONCE0 = 3'd4;
   localparam logic [2:0] REG_NONCE1 = 3'd5;
   localparam logic [2:0] REG_NONCE2 = 3'd6;
   localparam logic [2:0] REG_MODE   = 3'd7;

   localparam logic [4:0] MODE_RESET = 5'd22;

   localparam logic [1:0] NONCE_NONE = 2'd0;
   localparam logic [1:0] NONCE_8    = 2'd1;
   localparam logic [1:0] NONCE_12   = 2'd2;
   localparam logic [1:0] NONCE_24   = 2'd3;

   localparam logic [31:0] SIGMA0    = 32'h61707865;
   localparam logic [31:0] SIGMA1_16 = 32'h3120646e;
   localparam logic [31:0] SIGMA2_16 = 32'h79622d36;
   localparam logic [31:0] SIGMA1_32 = 32'h3320646e;
   localparam logic [31:0] SIGMA2_32 = 32'h79622d32;
   localparam logic [31:0] SIGMA3    = 32'h6b206574;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [7:0]  data_byte;
      logic [63:0] seek_offset;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       status;
   } rsp_payload_type;

   typedef struct packed {
      logic [63:0] key01;
      logic [63:0] key23;
      logic [63:0] key45;
      logic [63:0] key67;
      logic [63:0] nonce0;
      logic [63:0] nonce1;
      logic [63:0] nonce2;
      logic [4:0]  mode;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HROUND,
      ST_HDONE,
      ST_ROUND,
      ST_FINAL,
      ST_RESP
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic       load_init;   // build block from config
      logic       load_seek;   // set counter from seek offset
      logic       work_copy;   // copy block into working state
      logic       do_round;    // one double-round half
      logic       hchacha_fin; // fold hchacha result into block
      logic       finish;      // add, write keystream, bump counter
      logic       set_pos_seek;
      logic       pos_advance;
      logic       pos_clear;
      logic       cap_cipher;  // capture cipher output byte
      logic       set_started;
   } dp_cmd_type;

   typedef struct packed {
      logic       started;
      logic       last_byte;
      logic       nonce_x;
      logic [4:0] nrounds;     // half-rounds (column or diagonal) needed
   } dp_status_type;

   typedef logic [31:0] word_type;
   typedef word_type [15:0] block_type;

   function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned n);
      rotl = (v << n) | (v >> (32 - n));
   endfunction

   function automatic logic [127:0] qr(input logic [31:0] a_i, input logic [31:0] b_i,
                                       input logic [31:0] c_i, input logic [31:0] d_i);
      logic [31:0] a, b, c, d;
      a = a_i; b = b_i; c = c_i; d = d_i;
      a = a + b; d = rotl(d ^ a, 16);
      c = c + d; b = rotl(b ^ c, 12);
      a = a + b; d = rotl(d ^ a, 8);
      c = c + d; b = rotl(b ^ c, 7);
      qr = {a, b, c, d};
   endfunction

endpackage

FILE: rtl/ccsc_datapath.sv
// Datapath: block words, round state that holds the keystream, position and output byte
module ccsc_datapath
   import ccsc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  cfg_type         cfg,
   input  req_payload_type req,
   input  dp_cmd_type      cmd,
   input  logic            odd_half,
   output dp_status_type   stat,
   output logic [7:0]      cipher_byte
);

   block_type   blk_ff, blk_in;
   block_type   x_ff, x_in;
   logic [5:0]  pos_ff, pos_in;
   logic        started_ff, started_in;
   logic [7:0]  byte_ff, byte_in;
   logic [63:0] ctr;

   assign ctr = req.seek_offset >> 6;

   always_comb begin
      logic [127:0] q0, q1, q2, q3;
      blk_in     = blk_ff;
      x_in       = x_ff;
      pos_in     = pos_ff;
      started_in = started_ff;
      byte_in    = byte_ff;
      q0 = '0; q1 = '0; q2 = '0; q3 = '0;
      if (cmd.load_init) begin
         blk_in[0] = SIGMA0;
         blk_in[1] = cfg.mode[2] ? SIGMA1_32 : SIGMA1_16;
         blk_in[2] = cfg.mode[2] ? SIGMA2_32 : SIGMA2_16;
         blk_in[3] = SIGMA3;
         blk_in[4] = cfg.key01[31:0];
         blk_in[5] = cfg.key01[63:32];
         blk_in[6] = cfg.key23[31:0];
         blk_in[7] = cfg.key23[63:32];
         blk_in[8]  = cfg.mode[2] ? cfg.key45[31:0]  : cfg.key01[31:0];
         blk_in[9]  = cfg.mode[2] ? cfg.key45[63:32] : cfg.key01[63:32];
         blk_in[10] = cfg.mode[2] ? cfg.key67[31:0]  : cfg.key23[31:0];
         blk_in[11] = cfg.mode[2] ? cfg.key67[63:32] : cfg.key23[63:32];
         blk_in[12] = '0; blk_in[13] = '0; blk_in[14] = '0; blk_in[15] = '0;
         case (cfg.mode[4:3])
            NONCE_8: begin
               blk_in[14] = cfg.nonce0[31:0];
               blk_in[15] = cfg.nonce0[63:32];
            end
            NONCE_12: begin
               blk_in[13] = cfg.nonce0[31:0];
               blk_in[14] = cfg.nonce0[63:32];
               blk_in[15] = cfg.nonce1[31:0];
            end
            NONCE_24: begin
               blk_in[12] = cfg.nonce0[31:0];
               blk_in[13] = cfg.nonce0[63:32];
               blk_in[14] = cfg.nonce1[31:0];
               blk_in[15] = cfg.nonce1[63:32];
            end
            default: ;
         endcase
      end
      if (cmd.load_seek) begin
         blk_in[12] = ctr[31:0];
         blk_in[13] = blk_ff[13] + ctr[63:32];
      end
      if (cmd.work_copy) x_in = blk_in;
      if (cmd.do_round) begin
         if (!odd_half) begin
            q0 = qr(x_ff[0], x_ff[4], x_ff[8],  x_ff[12]);
            q1 = qr(x_ff[1], x_ff[5], x_ff[9],  x_ff[13]);
            q2 = qr(x_ff[2], x_ff[6], x_ff[10], x_ff[14]);
            q3 = qr(x_ff[3], x_ff[7], x_ff[11], x_ff[15]);
            {x_in[0], x_in[4], x_in[8],  x_in[12]} = q0;
            {x_in[1], x_in[5], x_in[9],  x_in[13]} = q1;
            {x_in[2], x_in[6], x_in[10], x_in[14]} = q2;
            {x_in[3], x_in[7], x_in[11], x_in[15]} = q3;
         end else begin
            q0 = qr(x_ff[0], x_ff[5], x_ff[10], x_ff[15]);
            q1 = qr(x_ff[1], x_ff[6], x_ff[11], x_ff[12]);
            q2 = qr(x_ff[2], x_ff[7], x_ff[8],  x_ff[13]);
            q3 = qr(x_ff[3], x_ff[4], x_ff[9],  x_ff[14]);
            {x_in[0], x_in[5], x_in[10], x_in[15]} = q0;
            {x_in[1], x_in[6], x_in[11], x_in[12]} = q1;
            {x_in[2], x_in[7], x_in[8],  x_in[13]} = q2;
            {x_in[3], x_in[4], x_in[9],  x_in[14]} = q3;
         end
      end
      if (cmd.hchacha_fin) begin
         for (int i = 0; i < 4; i++) begin
            blk_in[4 + i] = x_ff[i];
            blk_in[8 + i] = x_ff[12 + i];
         end
         blk_in[12] = '0;
         blk_in[13] = '0;
         blk_in[14] = cfg.nonce2[31:0];
         blk_in[15] = cfg.nonce2[63:32];
         x_in = blk_in;
      end
      if (cmd.finish) begin
         // keystream words stay in the round state until the next block
         for (int i = 0; i < 16; i++) x_in[i] = x_ff[i] + blk_ff[i];
         blk_in[12] = blk_ff[12] + 32'd1;
         if (blk_ff[12] == 32'hFFFF_FFFF) blk_in[13] = blk_ff[13] + 32'd1;
      end
      if (cmd.pos_clear)    pos_in = '0;
      if (cmd.set_pos_seek) pos_in = req.seek_offset[5:0];
      if (cmd.pos_advance)  pos_in = pos_ff + 6'd1;
      if (cmd.set_started)  started_in = 1'b1;
      if (cmd.cap_cipher)
         byte_in = req.data_byte ^ x_ff[pos_ff[5:2]][{pos_ff[1:0], 3'b000} +: 8];
   end

   always_ff @(posedge clock) begin
      blk_ff  <= blk_in;
      x_ff    <= x_in;
      byte_ff <= byte_in;
      if (reset) begin
         pos_ff     <= '0;
         started_ff <= 1'b0;
      end else begin
         pos_ff     <= pos_in;
         started_ff <= started_in;
      end
   end

   always_comb begin
      stat.started   = started_ff;
      stat.last_byte = (pos_ff == 6'd63);
      stat.nonce_x   = (cfg.mode[4:3] == NONCE_24);
      case (cfg.mode[1:0])
         2'd0:    stat.nrounds = 5'd8;
         2'd1:    stat.nrounds = 5'd12;
         default: stat.nrounds = 5'd20;
      endcase
   end

   assign cipher_byte = byte_ff;

endmodule

FILE: rtl/ccsc_control.sv
// Controller: sequences restart, seek and cipher items and the round iterations
module ccsc_control
   import ccsc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload,
   input  dp_status_type   stat,
   input  logic [7:0]      cipher_byte,
   output dp_cmd_type      cmd,
   output logic            odd_half
);

   state_type   state_ff, state_in;
   logic [4:0]  rnd_ff, rnd_in;
   logic        status_ff, status_in;
   logic        zero_ff, zero_in;
   logic        accept;

   assign accept    = req_valid && !req_stall;
   assign odd_half  = rnd_ff[0];
   assign rsp_valid = (state_ff == ST_RESP);
   assign rsp_payload.out_byte = zero_ff ? 8'd0 : cipher_byte;
   assign rsp_payload.status   = status_ff;

   always_comb begin
      state_in  = state_ff;
      rnd_in    = rnd_ff;
      status_in = status_ff;
      zero_in   = zero_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (accept) begin
               status_in = 1'b0;
               zero_in   = 1'b1;
               rnd_in    = '0;
               if (req_payload.req_type == REQ_RESTART) begin
                  cmd.load_init   = 1'b1;
                  cmd.work_copy   = 1'b1;
                  cmd.pos_clear   = 1'b1;
                  cmd.set_started = 1'b1;
                  state_in = stat.nonce_x ? ST_HROUND : ST_ROUND;
               end else if (!stat.started) begin
                  status_in = 1'b1;
                  state_in  = ST_RESP;
               end else if (req_payload.req_type == REQ_SEEK) begin
                  cmd.load_seek    = 1'b1;
                  cmd.work_copy    = 1'b1;
                  cmd.set_pos_seek = 1'b1;
                  state_in = ST_ROUND;
               end else if (req_payload.req_type == REQ_CIPHER) begin
                  cmd.cap_cipher = 1'b1;
                  zero_in = 1'b0;
                  if (stat.last_byte) begin
                     cmd.pos_clear = 1'b1;
                     cmd.work_copy = 1'b1;
                     state_in = ST_ROUND;
                  end else begin
                     cmd.pos_advance = 1'b1;
                     state_in = ST_RESP;
                  end
               end else begin
                  state_in = ST_RESP;
               end
            end
         end
         ST_HROUND: begin
            cmd.do_round = 1'b1;
            rnd_in = rnd_ff + 5'd1;
            if (rnd_in == stat.nrounds) state_in = ST_HDONE;
         end
         ST_HDONE: begin
            cmd.hchacha_fin = 1'b1;
            rnd_in   = '0;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            cmd.do_round = 1'b1;
            rnd_in = rnd_ff + 5'd1;
            if (rnd_in == stat.nrounds) state_in = ST_FINAL;
         end
         ST_FINAL: begin
            cmd.finish = 1'b1;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_stall) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      rnd_ff    <= rnd_in;
      status_ff <= status_in;
      zero_ff   <= zero_in;
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

endmodule

FILE: rtl/chacha_stream_cipher_unit.sv
// Top level: ChaCha byte-stream cipher unit with register port
//
//  port group | direction | transfer
//  req_*      | in        | one request (restart, seek, cipher byte)
//  rsp_*      | out       | one result byte and status per request
//  csr_*      | in/out    | register write/read, 64-bit data
//
// A cipher byte inside a block needs no round work; its result waits only on the output.
// Restart, seek and the byte that ends a block run one round per cycle
// through the shared round unit; XChaCha restarts run the HChaCha rounds first.
// Synchronous reset clears control state; the mode register resets to 22.
// A stalled result holds the unit; no request is taken until it transfers.
module chacha_stream_cipher_unit
   import ccsc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_payload_type       req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_payload_type       rsp_payload,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [63:0]           csr_pwdata,
   output logic [63:0]           csr_prdata,
   output logic                  csr_pready
);

   cfg_type       cfg_ff, cfg_in;
   dp_cmd_type    cmd;
   dp_status_type stat;
   logic [7:0]    cipher_byte;
   logic          odd_half;
   logic [2:0]    reg_idx;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[5:3];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_psel && csr_penable && csr_pwrite) begin
         case (reg_idx)
            REG_KEY01:  cfg_in.key01  = csr_pwdata;
            REG_KEY23:  cfg_in.key23  = csr_pwdata;
            REG_KEY45:  cfg_in.key45  = csr_pwdata;
            REG_KEY67:  cfg_in.key67  = csr_pwdata;
            REG_NONCE0: cfg_in.nonce0 = csr_pwdata;
            REG_NONCE1: cfg_in.nonce1 = csr_pwdata;
            REG_NONCE2: cfg_in.nonce2 = csr_pwdata;
            REG_MODE:   cfg_in.mode   = csr_pwdata[4:0];
            default: ;
         endcase
      end
      case (reg_idx)
         REG_KEY01:  csr_prdata = cfg_ff.key01;
         REG_KEY23:  csr_prdata = cfg_ff.key23;
         REG_KEY45:  csr_prdata = cfg_ff.key45;
         REG_KEY67:  csr_prdata = cfg_ff.key67;
         REG_NONCE0: csr_prdata = cfg_ff.nonce0;
         REG_NONCE1: csr_prdata = cfg_ff.nonce1;
         REG_NONCE2: csr_prdata = cfg_ff.nonce2;
         REG_MODE:   csr_prdata = {59'd0, cfg_ff.mode};
         default:    csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= {{7{64'd0}}, MODE_RESET};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ccsc_control u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .stat(stat), .cipher_byte(cipher_byte), .cmd(cmd), .odd_half(odd_half)
   );

   ccsc_datapath u_dp (
      .clock(clock), .reset(reset), .cfg(cfg_ff), .req(req_payload),
      .cmd(cmd), .odd_half(odd_half), .stat(stat), .cipher_byte(cipher_byte)
   );

endmodule

FILE: bench/chacha_stream_cipher_unit_tb.sv
// Testbench for the ChaCha stream cipher unit: random and directed requests against a predictor
`timescale 1ns / 1ps

module chacha_stream_cipher_unit_tb
   import ccsc_pkg::*;
;

   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam logic [1:0] REQ_UNKNOWN = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_payload_type req_payload = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_payload_type rsp_payload;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [63:0] csr_pwdata = '0;
   logic [63:0] csr_prdata;
   logic csr_pready;

   chacha_stream_cipher_unit dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   logic [63:0] key_reg [4];
   logic [63:0] nonce_reg [3];
   logic [4:0]  mode_reg;
   logic [31:0] blk [16];
   logic [7:0]  kstream [64];
   logic [5:0]  pos;
   logic        started;

   req_payload_type pending_reqs [$];
   rsp_payload_type expected_rsps [$];
   int unsigned errors = 0;
   int unsigned cycles = 0;
   int unsigned hold_cycles = 0;
   bit send_paused = 1'b0;
   bit req_taken = 1'b0;
   int unsigned burst_left = 0;
   int unsigned gap_left = 0;

   function automatic logic [31:0] rl(logic [31:0] v, int n);
      return (v << n) | (v >> (32 - n));
   endfunction

   task automatic quarter(inout logic [31:0] x [16], input int a, b, c, d);
      x[a] += x[b]; x[d] = rl(x[d] ^ x[a], 16);
      x[c] += x[d]; x[b] = rl(x[b] ^ x[c], 12);
      x[a] += x[b]; x[d] = rl(x[d] ^ x[a], 8);
      x[c] += x[d]; x[b] = rl(x[b] ^ x[c], 7);
   endtask

   task automatic scramble(inout logic [31:0] x [16]);
      int n;
      n = (mode_reg[1:0] == 2'd0) ? 4 : (mode_reg[1:0] == 2'd1) ? 6 : 10;
      for (int i = 0; i < n; i++) begin
         quarter(x, 0, 4, 8, 12); quarter(x, 1, 5, 9, 13);
         quarter(x, 2, 6, 10, 14); quarter(x, 3, 7, 11, 15);
         quarter(x, 0, 5, 10, 15); quarter(x, 1, 6, 11, 12);
         quarter(x, 2, 7, 8, 13); quarter(x, 3, 4, 9, 14);
      end
   endtask

   task automatic refill_keystream();
      logic [31:0] x [16];
      logic [31:0] w;
      x = blk;
      scramble(x);
      for (int i = 0; i < 16; i++) begin
         w = x[i] + blk[i];
         for (int b = 0; b < 4; b++) kstream[4*i+b] = w[8*b +: 8];
      end
      blk[12]++;
      if (blk[12] == 32'd0) blk[13]++;
   endtask

   task automatic load_block();
      logic [31:0] x [16];
      logic [1:0] nm;
      nm = mode_reg[4:3];
      blk[0] = SIGMA0;
      blk[1] = mode_reg[2] ? SIGMA1_32 : SIGMA1_16;
      blk[2] = mode_reg[2] ? SIGMA2_32 : SIGMA2_16;
      blk[3] = SIGMA3;
      for (int i = 0; i < 4; i++) blk[4+i] = key_reg[i/2][32*(i%2) +: 32];
      for (int i = 0; i < 4; i++)
         blk[8+i] = mode_reg[2] ? key_reg[2+i/2][32*(i%2) +: 32] : blk[4+i];
      for (int i = 12; i < 16; i++) blk[i] = '0;
      case (nm)
         NONCE_8: begin
            blk[14] = nonce_reg[0][31:0]; blk[15] = nonce_reg[0][63:32];
         end
         NONCE_12: begin
            blk[13] = nonce_reg[0][31:0]; blk[14] = nonce_reg[0][63:32];
            blk[15] = nonce_reg[1][31:0];
         end
         NONCE_24: begin
            blk[12] = nonce_reg[0][31:0]; blk[13] = nonce_reg[0][63:32];
            blk[14] = nonce_reg[1][31:0]; blk[15] = nonce_reg[1][63:32];
            x = blk;
            scramble(x);
            for (int i = 0; i < 4; i++) begin
               blk[4+i] = x[i];
               blk[8+i] = x[12+i];
            end
            blk[12] = '0; blk[13] = '0;
            blk[14] = nonce_reg[2][31:0]; blk[15] = nonce_reg[2][63:32];
         end
         default: ;
      endcase
      refill_keystream();
      pos = '0;
      started = 1'b1;
   endtask

   task automatic predict_cipher(input req_payload_type r);
      rsp_payload_type e;
      logic [57:0] ctr;
      e = '0;
      if (r.req_type == REQ_RESTART) load_block();
      else if (!started) e.status = 1'b1;
      else if (r.req_type == REQ_SEEK) begin
         ctr = r.seek_offset[63:6];
         blk[12] = ctr[31:0];
         blk[13] += {6'd0, ctr[57:32]};
         refill_keystream();
         pos = r.seek_offset[5:0];
      end else if (r.req_type == REQ_CIPHER) begin
         e.out_byte = r.data_byte ^ kstream[pos];
         if (pos == 6'd63) begin
            refill_keystream();
            pos = '0;
         end else pos++;
      end
      expected_rsps.push_back(e);
   endtask

   task automatic report_mismatch(input string what, input logic [63:0] got, want);
      $display("mismatch %s: got %0h want %0h", what, got, want);
      errors++;
   endtask

   // driver
   always @(negedge clock) begin
      if (!reset) begin
         if (req_taken) begin
            void'(pending_reqs.pop_front());
         end
         if (!req_valid || req_taken) begin
            if (gap_left > 0) gap_left--;
            if (pending_reqs.size() > 0 && !send_paused && gap_left == 0) begin
               req_valid <= 1'b1;
               req_payload <= pending_reqs[0];
               if (burst_left > 0) burst_left--;
               else begin
                  burst_left = $urandom_range(0, 20);
                  gap_left = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
               end
            end else req_valid <= 1'b0;
         end
      end
   end

   // receiver stall pattern
   always @(negedge clock) begin
      if (!reset) begin
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_stall <= 1'b1;
         end else rsp_stall <= (cycles % 300 < 150) ? 1'b0 : ($urandom_range(0, 3) == 0);
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_payload_type e;
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
      req_taken = !reset && req_valid && !req_stall;
      if (req_taken) predict_cipher(req_payload);
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0)
            report_mismatch("unexpected transfer", 64'(rsp_payload), 64'd0);
         else begin
            e = expected_rsps.pop_front();
            if (rsp_payload.out_byte !== e.out_byte)
               report_mismatch("out_byte", 64'(rsp_payload.out_byte), 64'(e.out_byte));
            if (rsp_payload.status !== e.status)
               report_mismatch("status", 64'(rsp_payload.status), 64'(e.status));
         end
      end
   end

   task automatic drain();
      while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_csr(input logic [2:0] idx, input logic [63:0] value);
      @(negedge clock);
      csr_psel <= 1'b1; csr_pwrite <= 1'b1; csr_penable <= 1'b0;
      csr_paddr <= CSR_ADDR_W'({idx, 3'b000}); csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      if (idx == REG_MODE) mode_reg = value[4:0];
      else if (idx <= REG_KEY67) key_reg[idx[1:0]] = value;
      else nonce_reg[2'(idx - REG_NONCE0)] = value;
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   function automatic req_payload_type make_req(logic [1:0] t, logic [7:0] d, logic [63:0] o);
      req_payload_type r;
      r.req_type = t; r.data_byte = d; r.seek_offset = o;
      return r;
   endfunction

   task automatic random_config(input logic [4:0] m);
      for (int i = 0; i < 7; i++) write_csr(3'(i), rand64());
      write_csr(REG_MODE, 64'(m));
   endtask

   initial begin
      logic [63:0] off;
      for (int i = 0; i < 4; i++) key_reg[i] = '0;
      for (int i = 0; i < 3; i++) nonce_reg[i] = '0;
      mode_reg = MODE_RESET;
      for (int i = 0; i < 16; i++) blk[i] = '0;
      for (int i = 0; i < 64; i++) kstream[i] = '0;
      pos = '0;
      started = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // not started, unknown request, then defaults
      pending_reqs.push_back(make_req(REQ_CIPHER, 8'hff, '0));
      pending_reqs.push_back(make_req(REQ_SEEK, 8'h00, '1));
      pending_reqs.push_back(make_req(REQ_UNKNOWN, 8'h5a, '0));
      pending_reqs.push_back(make_req(REQ_RESTART, 8'h00, '0));
      pending_reqs.push_back(make_req(REQ_CIPHER, 8'h00, '0));
      pending_reqs.push_back(make_req(REQ_UNKNOWN, 8'hff, '1));
      drain();

      write_csr(REG_KEY01, '1); write_csr(REG_KEY23, '1);
      write_csr(REG_KEY45, '1); write_csr(REG_KEY67, '1);
      write_csr(REG_NONCE0, '1); write_csr(REG_NONCE1, '1); write_csr(REG_NONCE2, '1);
      write_csr(REG_MODE, 64'd31);
      pending_reqs.push_back(make_req(REQ_RESTART, 8'h00, '0));
      // counter wrap from an offset whose block counter low word is all ones
      pending_reqs.push_back(make_req(REQ_SEEK, 8'h00, 64'hffff_ffff_ffff_ffc1));
      for (int i = 0; i < 64; i++)
         pending_reqs.push_back(make_req(REQ_CIPHER, 8'(i * 37), '0));
      pending_reqs.push_back(make_req(REQ_SEEK, 8'hff, 64'h0000_0000_ffff_ffff));
      pending_reqs.push_back(make_req(REQ_CIPHER, 8'haa, '0));
      drain();

      // random phases across modes, extremes included
      for (int ph = 0; ph < 10; ph++) begin
         random_config(ph == 0 ? 5'd0 : ph == 1 ? 5'd31 : 5'($urandom_range(0, 31)));
         pending_reqs.push_back(make_req(REQ_RESTART, 8'($urandom()), rand64()));
         for (int i = 0; i < 50; i++) begin
            case ($urandom_range(0, 19))
               0: pending_reqs.push_back(make_req(REQ_RESTART, 8'($urandom()), rand64()));
               1, 2: begin
                  off = rand64();
                  if ($urandom_range(0, 1)) off = {32'($urandom_range(0, 3)), off[31:0]};
                  pending_reqs.push_back(make_req(REQ_SEEK, 8'($urandom()), off));
               end
               3: pending_reqs.push_back(make_req(REQ_UNKNOWN, 8'($urandom()), rand64()));
               default: pending_reqs.push_back(make_req(REQ_CIPHER, 8'($urandom()), rand64()));
            endcase
         end
         if (ph == 3) begin
            @(negedge clock);
            hold_cycles = 400;
         end
         if (ph == 6) begin
            repeat (100) @(posedge clock);
            send_paused = 1'b1;
            while (expected_rsps.size() > 0 || req_valid) @(posedge clock);
            send_paused = 1'b0;
         end
         drain();
      end

      if (errors == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end
endmodule

FILE: filelist.f
rtl/ccsc_pkg.sv
rtl/ccsc_datapath.sv
rtl/ccsc_control.sv
rtl/chacha_stream_cipher_unit.sv
bench/chacha_stream_cipher_unit_tb.sv
